FILE: rtl/fgnd_pkg.sv
// ----------------------------------------------------------------------------
// fgnd_pkg
// Shared types and constants of the feature gallery nearest-distance block:
// beat payloads, control group between stages, register codes.
// ----------------------------------------------------------------------------
package fgnd_pkg;

  localparam int TRACK_W    = 6;
  localparam int VALUE_W    = 16;
  localparam int DIST_W     = 40;
  localparam int BUDGET_W   = 4;
  localparam int LEN_W      = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIST_W-1:0]   DIST_SAT     = '1;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 4'd8;
  localparam logic [LEN_W-1:0]    LEN_RESET    = 8'd128;
  localparam logic                FUNC_QUERY   = 1'b1;

  typedef enum logic {
    REG_BUDGET      = 1'b0,
    REG_FEATURE_LEN = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                       func;
    logic [TRACK_W-1:0]         track;
    logic signed [VALUE_W-1:0]  value;
  } feat_t;

  typedef struct packed {
    logic [TRACK_W-1:0] track_out;
    logic [DIST_W-1:0]  near_dist;
    logic               empty_res;
  } dist_t;

  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [TRACK_W-1:0] track;
  } lane_ctl_t;

endpackage

FILE: rtl/fgnd_cfg.sv
// ----------------------------------------------------------------------------
// fgnd_cfg
// APB-style register file: sample budget and feature length.
// ----------------------------------------------------------------------------
module fgnd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fgnd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fgnd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fgnd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [fgnd_pkg::BUDGET_W-1:0]   budget,
  output logic [fgnd_pkg::LEN_W-1:0]      feature_len
);
  import fgnd_pkg::*;

  cfg_reg_t sel;
  logic     wr;

  assign sel    = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget      <= BUDGET_RESET;
      feature_len <= LEN_RESET;
    end else if (wr) begin
      case (sel)
        REG_BUDGET:      budget      <= pwdata[BUDGET_W-1:0];
        REG_FEATURE_LEN: feature_len <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_BUDGET:      prdata = CFG_DATA_W'(budget);
      REG_FEATURE_LEN: prdata = CFG_DATA_W'(feature_len);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/fgnd_track_ram.sv
// ----------------------------------------------------------------------------
// fgnd_track_ram
// Per-track sample count and write slot, one entry per track. Cleared by a
// sweep after reset; a read that meets a write to the same entry takes the
// new data.
// ----------------------------------------------------------------------------
module fgnd_track_ram #(
  parameter  int TRACKS  = 64,
  parameter  int ENTRY_W = 7,
  localparam int IDX_W   = $clog2(TRACKS)
) (
  input  logic               clk,
  input  logic               rst,
  output logic               busy,
  input  logic               re,
  input  logic [IDX_W-1:0]   raddr,
  output logic [ENTRY_W-1:0] rdata,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  logic [ENTRY_W-1:0] wdata
);

  logic [ENTRY_W-1:0] mem [TRACKS];
  logic [IDX_W-1:0]   clr_idx;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  always_comb begin
    mem_we    = busy || we;
    mem_waddr = busy ? clr_idx : waddr;
    mem_wdata = busy ? '0 : wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      if (clr_idx == IDX_W'(TRACKS - 1)) begin
        busy <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

FILE: rtl/fgnd_gallery.sv
// ----------------------------------------------------------------------------
// fgnd_gallery
// Sample memory: one row per track and element, one lane per sample slot.
// Lane-wide writes, registered full-row reads.
// ----------------------------------------------------------------------------
module fgnd_gallery #(
  parameter  int DEPTH = 8192,
  parameter  int LANES = 8,
  parameter  int SW    = 16,
  localparam int AW    = $clog2(DEPTH),
  localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [LW-1:0]         wlane,
  input  logic [SW-1:0]         wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [LANES*SW-1:0]   rdata
);

  logic [LANES*SW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][wlane*SW +: SW] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fgnd_dist.sv
// ----------------------------------------------------------------------------
// fgnd_dist
// Distance lanes: squared difference per slot, saturating accumulation over
// the vector, then a registered minimum tree whose root is the result beat.
// ----------------------------------------------------------------------------
module fgnd_dist #(
  parameter  int LANES  = 8,
  parameter  int SW     = 16,
  localparam int CNT_W  = $clog2(LANES + 1),
  localparam int LVL    = (LANES > 1) ? $clog2(LANES) : 1,
  localparam int LEAVES = 2 ** LVL
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  fgnd_pkg::lane_ctl_t                 ctl,
  input  logic [CNT_W-1:0]                    n,
  input  logic signed [fgnd_pkg::VALUE_W-1:0] value,
  input  logic [LANES*SW-1:0]                 row,
  output logic                                res_valid,
  output fgnd_pkg::dist_t                     res
);
  import fgnd_pkg::*;

  localparam int SQ_W = 2 * VALUE_W;

  lane_ctl_t          ctl3;
  logic [CNT_W-1:0]   n3;
  logic [SQ_W-1:0]    sq      [LANES];
  logic [SQ_W-1:0]    sq_next [LANES];
  logic [DIST_W-1:0]  acc      [LANES];
  logic [DIST_W-1:0]  acc_next [LANES];
  logic               v4;
  logic [TRACK_W-1:0] trk4;
  logic [CNT_W-1:0]   n4;
  logic [DIST_W-1:0]  leaf [LEAVES];
  logic [DIST_W-1:0]  node [1:LEAVES-1];
  logic               sb_valid [LVL];
  logic [TRACK_W-1:0] sb_track [LVL];
  logic               sb_empty [LVL];

  // squared difference per slot
  always_comb begin
    logic [VALUE_W-1:0]          smp;
    logic signed [VALUE_W:0]     diff;
    logic signed [2*VALUE_W+1:0] prod;
    for (int l = 0; l < LANES; l++) begin
      smp        = VALUE_W'(row[l*SW +: SW]) << (VALUE_W - SW);
      diff       = $signed({smp[VALUE_W-1], smp}) - $signed({value[VALUE_W-1], value});
      prod       = diff * diff;
      sq_next[l] = prod[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
    end else if (adv) begin
      ctl3 <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n3 <= n;
      for (int l = 0; l < LANES; l++) begin
        sq[l] <= sq_next[l];
      end
    end
  end

  // saturating accumulation, restarted by the first element
  always_comb begin
    logic [DIST_W-1:0] base;
    logic [DIST_W:0]   sum;
    for (int l = 0; l < LANES; l++) begin
      base        = ctl3.first ? '0 : acc[l];
      sum         = (DIST_W+1)'(base) + (DIST_W+1)'(sq[l]);
      acc_next[l] = sum[DIST_W] ? DIST_SAT : sum[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl3.valid) begin
      for (int l = 0; l < LANES; l++) begin
        acc[l] <= acc_next[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= ctl3.valid && ctl3.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trk4 <= ctl3.track;
      n4   <= n3;
    end
  end

  // leaves: slots not held read as saturated
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < LANES) begin : g_used
      assign leaf[i] = (CNT_W'(i) < n4) ? acc[i] : DIST_SAT;
    end else begin : g_pad
      assign leaf[i] = DIST_SAT;
    end
  end

  for (genvar i = 1; i < LEAVES; i++) begin : g_node
    logic [DIST_W-1:0] lhs;
    logic [DIST_W-1:0] rhs;
    if (2 * i >= LEAVES) begin : g_bottom
      assign lhs = leaf[2*i - LEAVES];
      assign rhs = leaf[2*i + 1 - LEAVES];
    end else begin : g_inner
      assign lhs = node[2*i];
      assign rhs = node[2*i + 1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        node[i] <= (rhs < lhs) ? rhs : lhs;
      end
    end
  end

  // side band follows the tree levels
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LVL; k++) begin
        sb_valid[k] <= 1'b0;
      end
    end else if (adv) begin
      sb_valid[0] <= v4;
      for (int k = 1; k < LVL; k++) begin
        sb_valid[k] <= sb_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_track[0] <= trk4;
      sb_empty[0] <= (n4 == '0);
      for (int k = 1; k < LVL; k++) begin
        sb_track[k] <= sb_track[k-1];
        sb_empty[k] <= sb_empty[k-1];
      end
    end
  end

  always_comb begin
    res_valid     = sb_valid[LVL-1];
    res.track_out = sb_track[LVL-1];
    res.near_dist = node[1];
    res.empty_res = sb_empty[LVL-1];
  end

endmodule

FILE: rtl/feature_gallery_nearest_distance_top.sv
// ----------------------------------------------------------------------------
// feature_gallery_nearest_distance_top
// Per-track gallery of feature vectors. Store vectors fill a ring of samples
// per track; query vectors return the least squared distance to them.
//
//   channel | signals                            | beat
//   --------+------------------------------------+---------------------------
//   elem    | elem_valid, elem_stall, elem       | one feature element
//   res     | res_valid, res_stall, res          | one query result
//   apb     | psel, penable, pwrite, paddr, ...  | budget, feature_len
//
// One element per cycle while elem_stall is low, for stores and queries alike.
// A query result leaves after its last element has passed the gallery read,
// the square, the accumulate and the minimum tree.
// After reset the track-state memory is swept with elem_stall high;
// register writes are taken throughout.
// res_stall with a result waiting freezes the whole pipeline and raises
// elem_stall.
// ----------------------------------------------------------------------------
module feature_gallery_nearest_distance_top #(
  parameter int TRACKS      = 64,
  parameter int BUDGET_MAX  = 8,
  parameter int FEATURE_MAX = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            elem_valid,
  output logic                            elem_stall,
  input  fgnd_pkg::feat_t                 elem,
  output logic                            res_valid,
  input  logic                            res_stall,
  output fgnd_pkg::dist_t                 res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fgnd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fgnd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fgnd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import fgnd_pkg::*;

  localparam int SW      = (SAMPLE_BITS < VALUE_W) ? SAMPLE_BITS : VALUE_W;
  localparam int SLOT_W  = (BUDGET_MAX > 1) ? $clog2(BUDGET_MAX) : 1;
  localparam int CNT_W   = $clog2(BUDGET_MAX + 1);
  localparam int BCW     = (CNT_W > BUDGET_W) ? CNT_W : BUDGET_W;
  localparam int ELEM_W  = (FEATURE_MAX > 1) ? $clog2(FEATURE_MAX) : 1;
  localparam int LEN_EW  = $clog2(FEATURE_MAX + 1);
  localparam int LCW     = (LEN_EW > LEN_W) ? LEN_EW : LEN_W;
  localparam int TIW     = $clog2(TRACKS);
  localparam int DEPTH   = TRACKS * FEATURE_MAX;
  localparam int AW      = $clog2(DEPTH);
  localparam int ENTRY_W = CNT_W + SLOT_W;

  logic [BUDGET_W-1:0] budget;
  logic [LEN_W-1:0]    feature_len;
  logic [BCW-1:0]      eff_bud;
  logic [LCW-1:0]      eff_len;

  logic                adv;
  logic                busy;
  logic                accept;
  logic [ELEM_W-1:0]   cnt;
  logic                cur_func;
  logic [TRACK_W-1:0]  cur_track;
  logic                first;
  logic                func_now;
  logic [TRACK_W-1:0]  track_now;
  logic                last_now;
  logic [TRACK_W-1:0]  trk_mod [2**TRACK_W];

  logic                      s1_valid;
  logic                      s1_func;
  logic                      s1_first;
  logic                      s1_last;
  logic [TRACK_W-1:0]        s1_track;
  logic [ELEM_W-1:0]         s1_elem;
  logic signed [VALUE_W-1:0] s1_value;
  logic                      s1_query;

  logic [ENTRY_W-1:0] ts_rdata;
  logic [CNT_W-1:0]   vec_cnt;
  logic [SLOT_W-1:0]  vec_ws;
  logic [CNT_W-1:0]   cur_cnt;
  logic [SLOT_W-1:0]  cur_ws;
  logic [CNT_W-1:0]   cnt_new;
  logic [BCW-1:0]     ws_inc;
  logic [SLOT_W-1:0]  ws_new;
  logic               ts_we;

  logic [AW-1:0]            g_addr;
  logic                     g_we;
  logic                     g_re;
  logic [BUDGET_MAX*SW-1:0] g_rdata;

  lane_ctl_t                 ctl2;
  logic [CNT_W-1:0]          n2;
  logic signed [VALUE_W-1:0] value2;

  fgnd_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .budget      (budget),
    .feature_len (feature_len)
  );

  always_comb begin
    logic [BCW-1:0] bw;
    logic [LCW-1:0] fl;
    bw = BCW'(budget);
    fl = LCW'(feature_len);
    if (bw == '0) begin
      eff_bud = BCW'(1);
    end else if (bw > BCW'(BUDGET_MAX)) begin
      eff_bud = BCW'(BUDGET_MAX);
    end else begin
      eff_bud = bw;
    end
    if (fl == '0) begin
      eff_len = LCW'(1);
    end else if (fl > LCW'(FEATURE_MAX)) begin
      eff_len = LCW'(FEATURE_MAX);
    end else begin
      eff_len = fl;
    end
  end

  // track number folded onto the table size
  for (genvar i = 0; i < 2**TRACK_W; i++) begin : g_trk_mod
    assign trk_mod[i] = TRACK_W'(i % TRACKS);
  end

  // front: element count and vector header
  assign adv        = !res_valid || !res_stall;
  assign elem_stall = !adv || busy;
  assign accept     = elem_valid && !elem_stall;
  assign first      = (cnt == '0);
  assign func_now   = first ? elem.func : cur_func;
  assign track_now  = first ? trk_mod[elem.track] : cur_track;
  assign last_now   = (LCW'(cnt) + LCW'(1)) >= eff_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      cur_func  <= 1'b0;
      cur_track <= '0;
      s1_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      if (accept) begin
        cnt <= last_now ? '0 : cnt + 1'b1;
        if (first) begin
          cur_func  <= func_now;
          cur_track <= track_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func  <= func_now;
      s1_first <= first;
      s1_last  <= last_now;
      s1_track <= track_now;
      s1_elem  <= cnt;
      s1_value <= elem.value;
    end
  end

  // stage 1: track state, gallery access
  assign s1_query = (s1_func == FUNC_QUERY);
  assign cur_cnt  = s1_first ? ts_rdata[ENTRY_W-1:SLOT_W] : vec_cnt;
  assign cur_ws   = s1_first ? ts_rdata[SLOT_W-1:0] : vec_ws;
  assign cnt_new  = (BCW'(cur_cnt) < eff_bud) ? cur_cnt + 1'b1 : CNT_W'(eff_bud);
  assign ws_inc   = BCW'(cur_ws) + BCW'(1);
  assign ws_new   = (ws_inc >= eff_bud) ? '0 : SLOT_W'(ws_inc);
  assign ts_we    = adv && s1_valid && !s1_query && s1_last;

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      vec_cnt <= cur_cnt;
      vec_ws  <= cur_ws;
    end
  end

  fgnd_track_ram #(
    .TRACKS  (TRACKS),
    .ENTRY_W (ENTRY_W)
  ) u_track_ram (
    .clk   (clk),
    .rst   (rst),
    .busy  (busy),
    .re    (accept && first),
    .raddr (TIW'(track_now)),
    .rdata (ts_rdata),
    .we    (ts_we),
    .waddr (TIW'(s1_track)),
    .wdata ({cnt_new, ws_new})
  );

  assign g_addr = AW'(s1_track) * AW'(FEATURE_MAX) + AW'(s1_elem);
  assign g_we   = adv && s1_valid && !s1_query;
  assign g_re   = adv && s1_valid && s1_query;

  fgnd_gallery #(
    .DEPTH (DEPTH),
    .LANES (BUDGET_MAX),
    .SW    (SW)
  ) u_gallery (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_addr),
    .wlane (cur_ws),
    .wdata (s1_value[VALUE_W-1 -: SW]),
    .re    (g_re),
    .raddr (g_addr),
    .rdata (g_rdata)
  );

  // stage 2 control, only query elements go on
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else if (adv) begin
      ctl2.valid <= s1_valid && s1_query;
      ctl2.first <= s1_first;
      ctl2.last  <= s1_last;
      ctl2.track <= s1_track;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n2     <= cur_cnt;
      value2 <= s1_value;
    end
  end

  fgnd_dist #(
    .LANES (BUDGET_MAX),
    .SW    (SW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl       (ctl2),
    .n         (n2),
    .value     (value2),
    .row       (g_rdata),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

FILE: rtl/fgnd_checker.sv
// ----------------------------------------------------------------------------
// fgnd_checker
// Port-level checks of the feature gallery block, bound to the top level.
// ----------------------------------------------------------------------------
module fgnd_checker (
  input logic            clk,
  input logic            rst,
  input logic            elem_stall,
  input logic            res_valid,
  input logic            res_stall,
  input fgnd_pkg::dist_t res
);
  import fgnd_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_sweep_stall: assert property (@(posedge clk)
    rst |=> elem_stall)
    else $error("element taken during track-state sweep");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result beat right after reset");

  a_back_pressure: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> elem_stall)
    else $error("element taken while result stalled");

  a_empty_sat: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.empty_res |-> res.near_dist == DIST_SAT)
    else $error("empty gallery without saturated distance");

endmodule

bind feature_gallery_nearest_distance_top fgnd_checker u_fgnd_checker (
  .clk        (clk),
  .rst        (rst),
  .elem_stall (elem_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res        (res)
);

FILE: bench/feature_gallery_nearest_distance_top_tb.sv
// ----------------------------------------------------------------------------
// feature_gallery_nearest_distance_top_tb
// Self-checking bench for the feature gallery nearest-distance block. A short
// table of beats covers the extremes, both operations, empty tracks and the
// out-of-range register values. Random phases follow, each under its own
// budget and vector length and on its own set of tracks, with sender gaps and
// receiver stalls. Results are checked against the table's own values, else
// against a behavioural copy of the gallery kept inside the bench.
// ----------------------------------------------------------------------------
module feature_gallery_nearest_distance_top_tb;
  import fgnd_pkg::*;

  localparam int TRACKS        = 64;
  localparam int BUDGET_MAX    = 8;
  localparam int FEATURE_MAX   = 128;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  localparam logic FUNC_STORE = ~FUNC_QUERY;

  typedef enum logic {ROW_ELEM, ROW_CFG} row_kind_t;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    row_kind_t  kind;
    cfg_reg_t   reg_sel;
    logic [7:0] wval;
    feat_t      beat;
    logic       has_want;
    dist_t      want;
  } plan_row_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  elem_valid = 1'b0;
  logic                  elem_stall;
  feat_t                 elem       = '0;
  logic                  res_valid;
  logic                  res_stall  = 1'b0;
  dist_t                 res;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr      = '0;
  logic [CFG_DATA_W-1:0] pwdata     = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // gallery copy, per-track ring state and the running sums of one query
  logic signed [VALUE_W-1:0] gal [TRACKS][FEATURE_MAX][BUDGET_MAX];
  int unsigned               held [TRACKS];
  int unsigned               slot [TRACKS];
  logic [DIST_W-1:0]         acc  [BUDGET_MAX];
  int unsigned               elem_pos  = 0;
  logic                      cur_func  = FUNC_STORE;
  logic [TRACK_W-1:0]        cur_track = '0;
  logic [BUDGET_W-1:0]       budget_q  = BUDGET_RESET;
  logic [LEN_W-1:0]          len_q     = LEN_RESET;

  dist_t       due_distances [$];
  int unsigned bad_count     = 0;
  int unsigned cycles        = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;

  plan_row_t script [25] = '{
    '{ROW_CFG,  REG_BUDGET,      8'd1,   '0,                               1'b0, '0},
    '{ROW_CFG,  REG_FEATURE_LEN, 8'd1,   '0,                               1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_STORE, 6'd7,  16'sh7FFF},  1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_QUERY, 6'd7,  16'sh8000},  1'b1,
      '{6'd7, 40'h00FFFE0001, 1'b0}},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_QUERY, 6'd63, 16'sh0000},  1'b1,
      '{6'd63, DIST_SAT, 1'b1}},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_STORE, 6'd7,  16'sh8000},  1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_QUERY, 6'd7,  16'sh8000},  1'b1,
      '{6'd7, 40'd0, 1'b0}},
    '{ROW_CFG,  REG_BUDGET,      8'd0,   '0,                               1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_STORE, 6'd15, 16'sd100},   1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_STORE, 6'd15, -16'sd100},  1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_QUERY, 6'd15, 16'sd0},     1'b1,
      '{6'd15, 40'd10000, 1'b0}},
    '{ROW_CFG,  REG_FEATURE_LEN, 8'd0,   '0,                               1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_QUERY, 6'd7,  16'sh7FFF},  1'b1,
      '{6'd7, 40'h00FFFE0001, 1'b0}},
    '{ROW_CFG,  REG_BUDGET,      8'd12,  '0,                               1'b0, '0},
    '{ROW_CFG,  REG_FEATURE_LEN, 8'd2,   '0,                               1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_STORE, 6'd23, 16'sd1},     1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_QUERY, 6'd40, 16'sd2},     1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_STORE, 6'd23, 16'sd3},     1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_QUERY, 6'd31, -16'sd4},    1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_QUERY, 6'd23, 16'sd0},     1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_STORE, 6'd0,  16'sd0},     1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_STORE, 6'd55, -16'sd5},    1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_QUERY, 6'd12, 16'sh7FFF},  1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_QUERY, 6'd55, 16'sh8000},  1'b0, '0},
    '{ROW_ELEM, REG_BUDGET,      8'd0, '{FUNC_STORE, 6'd12, 16'sh8000},  1'b0, '0}
  };

  feature_gallery_nearest_distance_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .elem_valid (elem_valid),
    .elem_stall (elem_stall),
    .elem       (elem),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic note_mismatch(input string msg);
    bad_count++;
    if (bad_count <= REPORT_MAX) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    dist_t want;
    if (!rst && res_valid && !res_stall) begin
      if (due_distances.size() == 0) begin
        note_mismatch($sformatf("unexpected result track %0d dist %0h empty %0b",
                                res.track_out, res.near_dist, res.empty_res));
      end else begin
        want = due_distances.pop_front();
        if (res.track_out !== want.track_out || res.near_dist !== want.near_dist ||
            res.empty_res !== want.empty_res) begin
          note_mismatch($sformatf("want track %0d dist %0h empty %0b, got %0d %0h %0b",
                                  want.track_out, want.near_dist, want.empty_res,
                                  res.track_out, res.near_dist, res.empty_res));
        end
      end
    end
  end

  function automatic int unsigned eff_budget();
    if (budget_q == 0) return 1;
    if (budget_q > BUDGET_MAX) return BUDGET_MAX;
    return 32'(budget_q);
  endfunction

  function automatic int unsigned eff_len();
    if (len_q == 0) return 1;
    if (len_q > FEATURE_MAX) return FEATURE_MAX;
    return 32'(len_q);
  endfunction

  // one accepted element: store into the ring or accumulate the distances
  task automatic gallery_update(input feat_t beat, output bit emits, output dist_t got);
    int unsigned       n, bud, ws;
    longint            diff;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] best;
    emits = 1'b0;
    got   = '0;
    bud   = eff_budget();
    if (elem_pos == 0) begin
      cur_func  = beat.func;
      cur_track = beat.track;
      foreach (acc[s]) acc[s] = '0;
    end
    n = held[cur_track];
    if (cur_func != FUNC_QUERY) begin
      gal[cur_track][elem_pos][slot[cur_track]] = beat.value;
    end else begin
      for (int s = 0; s < n; s++) begin
        diff   = longint'($signed(gal[cur_track][elem_pos][s])) - longint'($signed(beat.value));
        sum    = (DIST_W+1)'(acc[s]) + (DIST_W+1)'(diff * diff);
        acc[s] = (sum > DIST_SAT) ? DIST_SAT : sum[DIST_W-1:0];
      end
    end
    if (elem_pos + 1 < eff_len()) begin
      elem_pos++;
      return;
    end
    elem_pos = 0;
    if (cur_func != FUNC_QUERY) begin
      ws               = slot[cur_track] + 1;
      held[cur_track]  = (held[cur_track] < bud) ? held[cur_track] + 1 : bud;
      slot[cur_track]  = (ws >= bud) ? 0 : ws;
    end else begin
      best = DIST_SAT;
      for (int s = 0; s < n; s++) if (acc[s] < best) best = acc[s];
      emits         = 1'b1;
      got.track_out = cur_track;
      got.near_dist = best;
      got.empty_res = (n == 0);
    end
  endtask

  task automatic push_elem(input feat_t beat, input logic has_want, input dist_t want);
    int    gap;
    bit    emits;
    dist_t got;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      elem_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    elem_valid <= 1'b1;
    elem       <= beat;
    do @(posedge clk); while (elem_stall);
    gallery_update(beat, emits, got);
    if (has_want) due_distances = {due_distances, want};
    else if (emits) due_distances = {due_distances, got};
    @(negedge clk);
  endtask

  // drop valid, let every result come out, then let stores finish too
  task automatic settle();
    elem_valid <= 1'b0;
    while (due_distances.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t r, input logic [7:0] v);
    logic [CFG_DATA_W-1:0] rd_want;
    rd_want = (r == REG_BUDGET) ? CFG_DATA_W'(v[BUDGET_W-1:0]) : CFG_DATA_W'(v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * int'(r));
    pwdata  <= CFG_DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (r == REG_BUDGET) budget_q = v[BUDGET_W-1:0];
    else len_q = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== rd_want)
      note_mismatch($sformatf("register %s read %0h, want %0h", r.name(), prdata, rd_want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // each phase owns tracks p*8 .. p*8+6, so no held sample sees a budget change
  task automatic run_phase(input int p, input logic [7:0] bud_w, input logic [7:0] len_w,
                           input idle_mode_t mode);
    int unsigned        n_len, vectors, span;
    feat_t              beat;
    logic               qf;
    logic [TRACK_W-1:0] t;
    settle();
    send_idle_pct = (mode == IDLE_SEND) ? 81 : (mode == IDLE_BOTH) ? 26 : 0;
    stall_pct     = (mode == IDLE_RECV) ? 81 : (mode == IDLE_BOTH) ? 26 : 0;
    cfg_write(REG_BUDGET, bud_w);
    cfg_write(REG_FEATURE_LEN, len_w);
    n_len   = eff_len();
    vectors = (40 / n_len > 4) ? 40 / n_len : 4;
    span    = (vectors >= 20) ? 6 : 1;
    for (int v = 0; v < vectors; v++) begin
      t  = TRACK_W'(p * 8 + $urandom_range(0, span));
      qf = (held[t] == 0) ? ($urandom_range(0, 99) < 15) : ($urandom_range(0, 99) < 50);
      for (int k = 0; k < n_len; k++) begin
        beat.func  = (k == 0) ? (qf ? FUNC_QUERY : FUNC_STORE) : 1'($urandom);
        beat.track = (k == 0) ? t : TRACK_W'($urandom);
        beat.value = pick_value();
        push_elem(beat, 1'b0, '0);
      end
    end
  endtask

  initial begin
    foreach (held[i]) begin
      held[i] = 0;
      slot[i] = 0;
    end
    foreach (acc[s]) acc[s] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        settle();
        cfg_write(script[i].reg_sel, script[i].wval);
      end else begin
        push_elem(script[i].beat, script[i].has_want, script[i].want);
      end
    end

    run_phase(0, 8'd2,  8'd3,   IDLE_NONE);
    run_phase(1, 8'd1,  8'd1,   IDLE_SEND);
    run_phase(2, 8'd0,  8'd0,   IDLE_RECV);
    run_phase(3, 8'd15, 8'd200, IDLE_BOTH);
    run_phase(4, 8'd8,  8'd4,   IDLE_NONE);
    run_phase(5, 8'd5,  8'd7,   IDLE_SEND);
    run_phase(6, 8'd3,  8'd2,   IDLE_RECV);
    run_phase(7, 8'd6,  8'd16,  IDLE_BOTH);
    settle();

    if (bad_count == 0 && due_distances.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
